[src/ctlc_pkg.sv]
// ----------------------------------------------------------------------------
// ctlc_pkg: shared types and constants
// Word and severity types, severity codes, register indexes and reset
// values for the CO2 trend level classifier.
// ----------------------------------------------------------------------------
package ctlc_pkg;

	localparam int WORD_W    = 16;
	localparam int SEV_W     = 2;
	localparam int CFG_IDX_W = 8;

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [SEV_W-1:0]     sev_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// severity codes
	localparam sev_t SEV_NONE   = 2'd0;
	localparam sev_t SEV_L1_DEC = 2'd1;
	localparam sev_t SEV_L1_INC = 2'd2;
	localparam sev_t SEV_L2     = 2'd3;

	// register indexes
	localparam cfg_idx_t REG_LEVEL_ONE = 8'd0;
	localparam cfg_idx_t REG_LEVEL_TWO = 8'd1;

	// register reset values
	localparam word_t LEVEL_ONE_RST = 16'd1000;
	localparam word_t LEVEL_TWO_RST = 16'd1500;

	// control from the sequencer to the max tracker
	typedef struct packed {
		logic clear;
		logic en;
	} trk_ctl_t;

endpackage

[src/ctlc_if.sv]
// ----------------------------------------------------------------------------
// ctlc_if: channel interfaces
// Reading, result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface ctlc_in_if;
	logic            valid;
	logic            ready;
	ctlc_pkg::word_t co2_ppm;
	logic            data_ready;

	modport source (output valid, output co2_ppm, output data_ready, input ready);
	modport sink   (input valid, input co2_ppm, input data_ready, output ready);
endinterface

interface ctlc_out_if;
	logic           valid;
	logic           ready;
	ctlc_pkg::sev_t severity_level;

	modport source (output valid, output severity_level, input ready);
	modport sink   (input valid, input severity_level, output ready);
endinterface

interface ctlc_cfg_if;
	logic               valid;
	logic               ready;
	ctlc_pkg::cfg_idx_t index;
	ctlc_pkg::word_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ctlc_cell.sv]
// ----------------------------------------------------------------------------
// ctlc_cell: one window cell
// Holds one reading; takes its left neighbor's word when the chain shifts.
// ----------------------------------------------------------------------------
module ctlc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ctlc_pkg::word_t d,
	output ctlc_pkg::word_t q
);
	import ctlc_pkg::*;

	word_t data_q;

	// window cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

[src/ctlc_tracker.sv]
// ----------------------------------------------------------------------------
// ctlc_tracker: running largest / second largest
// Consumes one word per enabled cycle; duplicates of the max count, so a
// max seen twice becomes the second largest as well.
// ----------------------------------------------------------------------------
module ctlc_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  ctlc_pkg::trk_ctl_t ctl,
	input  ctlc_pkg::word_t    sample,
	output ctlc_pkg::word_t    second
);
	import ctlc_pkg::*;

	word_t top_q;
	word_t second_q;

	// values are unsigned, so starting both at zero matches a fresh scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			second_q <= '0;
		end else if (ctl.clear) begin
			top_q    <= '0;
			second_q <= '0;
		end else if (ctl.en) begin
			if (sample > top_q) begin
				second_q <= top_q;
				top_q    <= sample;
			end else if (sample > second_q) begin
				second_q <= sample;
			end
		end
	end

	assign second = second_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= second_q)
		else $error("second largest above largest");

endmodule

[src/co2_trend_level_classifier.sv]
// ----------------------------------------------------------------------------
// co2_trend_level_classifier: CO2 severity level with trend
// Keeps a window of recent readings in a chain of cells, finds its second
// largest value by rotating the chain past a tracker, and classifies each
// reading into none / level 1 falling / level 1 rising / level 2.
//
//   channel  | dir | payload                     | handshake
//   ---------+-----+-----------------------------+-------------
//   sample   | in  | co2_ppm[15:0], data_ready   | valid/ready
//   result   | out | severity_level[1:0]         | valid/ready
//   cfg      | in  | index[7:0], data[15:0]      | valid/ready
//
// A ready reading is accepted, rotated through the tracker one step per
// window cell, then classified into the result register. A reading with
// data_ready low skips the rotation and repeats the held level.
// Reset clears the window, the level and both result/control registers;
// level registers return to 1000 and 1500 ppm. cfg is always ready.
// The result register holds an item while result.ready is low; the next
// reading is accepted meanwhile and waits at classification.
// ----------------------------------------------------------------------------
module co2_trend_level_classifier #(
	parameter int WINDOW_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	ctlc_in_if.sink    sample,
	ctlc_out_if.source result,
	ctlc_cfg_if.sink   cfg
);
	import ctlc_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            level_one_q;
	word_t            level_two_q;
	word_t            x_q;
	logic             ready_q;
	sev_t             sev_q;
	logic             res_valid_q;
	sev_t             res_level_q;

	logic     sample_acc;
	logic     slot_free;
	logic     emit_fire;
	logic     shift_en;
	word_t    chain_head;
	word_t    cell_q [WINDOW_DEPTH];
	trk_ctl_t trk_ctl;
	word_t    win_second;
	sev_t     cls;
	sev_t     emit_val;
	logic [20:0] x20, l1_19, l1_21, m20;
	logic [16:0] x2, l1_plus_m;

	assign sample_acc   = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign slot_free    = !res_valid_q || result.ready;
	assign emit_fire    = (state_q == ST_EMIT) && slot_free;
	assign result.valid = res_valid_q;
	assign result.severity_level = res_level_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_one_q <= LEVEL_ONE_RST;
			level_two_q <= LEVEL_TWO_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LEVEL_ONE: level_one_q <= cfg.data;
				REG_LEVEL_TWO: level_two_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// window chain: new reading enters at cell 0, rotation during scan
	assign chain_head = (state_q == ST_IDLE) ? sample.co2_ppm : cell_q[WINDOW_DEPTH-1];
	assign shift_en   = (sample_acc && sample.data_ready) || (state_q == ST_SCAN);

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		ctlc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift_en),
			.d      ((i == 0) ? chain_head : cell_q[(i == 0) ? 0 : i-1]),
			.q      (cell_q[i])
		);
	end

	// tracker watches the tail cell while the chain rotates
	assign trk_ctl = '{clear: sample_acc, en: (state_q == ST_SCAN)};

	ctlc_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (trk_ctl),
		.sample  (cell_q[WINDOW_DEPTH-1]),
		.second  (win_second)
	);

	// classification, factors as exact integer compares
	assign x20       = 21'(x_q) * 21'd20;
	assign l1_19     = 21'(level_one_q) * 21'd19;
	assign l1_21     = 21'(level_one_q) * 21'd21;
	assign m20       = 21'(win_second) * 21'd20;
	assign x2        = {x_q, 1'b0};
	assign l1_plus_m = 17'(level_one_q) + 17'(win_second);

	always_comb begin
		if (x_q < level_one_q) begin
			cls = (sev_q != SEV_NONE && x20 > l1_19) ? SEV_L1_DEC : SEV_NONE;
		end else if (x_q >= level_two_q) begin
			cls = SEV_L2;
		end else if (m20 < l1_21) begin
			cls = (x_q <= win_second) ? SEV_L1_DEC : SEV_L1_INC;
		end else begin
			cls = (x2 <= l1_plus_m) ? SEV_L1_DEC : SEV_L1_INC;
		end
	end

	assign emit_val = ready_q ? cls : sev_q;

	// latched reading
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			x_q <= sample.co2_ppm;
		end
	end

	// sequencer and held level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			sev_q       <= SEV_NONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_acc) begin
						ready_q <= sample.data_ready;
						cnt_q   <= '0;
						state_q <= sample.data_ready ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						sev_q   <= emit_val;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register: loaded at emit, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_level_q <= SEV_NONE;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
			res_level_q <= emit_val;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc && !sample.data_ready |=> state_q == ST_EMIT && $stable(sev_q))
		else $error("not-ready item disturbed state");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && cnt_q == CNT_LAST |=> state_q == ST_EMIT)
		else $error("scan overran window");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && slot_free |=> result.valid && result.severity_level == sev_q)
		else $error("result and held level disagree");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc && sample.data_ready |=> cell_q[0] == $past(sample.co2_ppm))
		else $error("reading not written to window");

endmodule
